// ===== sv/ugcl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugcl_pkg: shared types and codes for the uniform grid cell list
// Command, status and register index codes, payload structs and the sequencer state type.
// ----------------------------------------------------------------------------
package ugcl_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_MOVE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NEXT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_COLS = 2'd0,
    REG_ROWS = 2'd1,
    REG_CW   = 2'd2,
    REG_CH   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  point_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  result_index;
    logic        neighbor_found;
    logic [15:0] neighbor_x;
    logic [15:0] neighbor_y;
    logic [9:0]  cell_id;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_DIVX,
    S_DIVY,
    S_CELL,
    S_DISPATCH,
    S_ADD_RD,
    S_ADD_WR,
    S_MV_RD,
    S_MV_CHK,
    S_MV_UNL,
    S_MV_UNL2,
    S_MV_HRD,
    S_MV_HWR,
    S_Q_RD,
    S_Q_WR,
    S_WALK_RD,
    S_WALK_NX,
    S_WALK_SLOT,
    S_WALK_POS,
    S_WALK_OUT,
    S_DONE
  } state_t;

endpackage

// ===== sv/ugcl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ugcl_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ugcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/uniform_grid_cell_list_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_grid_cell_list_top: 2-D uniform grid cell list with neighbor walk
// Points are binned into cells; each cell is a doubly linked list, newest
// first. Add, move, query of the 3x3 cells around a position, next neighbor.
// ----------------------------------------------------------------------------
// Usage: pulse start with in_item while busy is low. Exactly one result
// appears later for one cycle with out_valid; the receiver cannot stall it.
// busy drops in the cycle the result is shown, so the next item can be
// accepted at the edge that ends that cycle. Two 16-step restoring
// divisions on one shared subtract unit find the cell (not used by next),
// then a sequencer reads and writes the list memories (a query reads nine
// cell heads; a walk skips up to nine empty slots, one per cycle). After
// reset a clearing pass writes every cell head to null, with busy high.
// ----------------------------------------------------------------------------
module uniform_grid_cell_list_top #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_CELLS  = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ugcl_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output ugcl_pkg::out_item_t  out_item,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int PW = $clog2(MAX_POINTS);
  localparam int PN = PW + 1;
  localparam int CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam logic [PN-1:0] NULL_IDX = PN'(MAX_POINTS);
  localparam logic [CW-1:0] CELL_MAX = CW'(MAX_CELLS - 1);

  // configuration
  logic [5:0]  cols_r, rows_r;
  logic [15:0] cw_r, ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 6'd16;
      rows_r <= 6'd12;
      cw_r   <= 16'd800;
      ch_r   <= 16'd800;
    end else if (cfg_we) begin
      unique case (ugcl_pkg::reg_idx_t'(cfg_index))
        ugcl_pkg::REG_COLS: cols_r <= cfg_data[5:0];
        ugcl_pkg::REG_ROWS: rows_r <= cfg_data[5:0];
        ugcl_pkg::REG_CW:   cw_r   <= cfg_data;
        ugcl_pkg::REG_CH:   ch_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [5:0] ecols, erows;
  assign ecols = (cols_r == 6'd0) ? 6'd1 : ((cols_r > 6'd32) ? 6'd32 : cols_r);
  assign erows = (rows_r == 6'd0) ? 6'd1 : ((rows_r > 6'd32) ? 6'd32 : rows_r);

  // memories
  logic          hd_we;  logic [CW-1:0] hd_a;  logic [PN-1:0] hd_wd, hd_rd;
  logic          nx_we;  logic [PW-1:0] nx_a;  logic [PN-1:0] nx_wd, nx_rd;
  logic          pv_we;  logic [PW-1:0] pv_a;  logic [PN-1:0] pv_wd, pv_rd;
  logic          pc_we;  logic [PW-1:0] pc_a;  logic [CW-1:0] pc_wd, pc_rd;
  logic          ps_we;  logic [PW-1:0] ps_a;  logic [31:0]   ps_wd, ps_rd;

  ugcl_ram #(.WIDTH(PN), .DEPTH(MAX_CELLS)) u_head (
    .clk(clk), .we(hd_we), .addr(hd_a), .wdata(hd_wd), .rdata(hd_rd));
  ugcl_ram #(.WIDTH(PN), .DEPTH(MAX_POINTS)) u_next (
    .clk(clk), .we(nx_we), .addr(nx_a), .wdata(nx_wd), .rdata(nx_rd));
  ugcl_ram #(.WIDTH(PN), .DEPTH(MAX_POINTS)) u_prev (
    .clk(clk), .we(pv_we), .addr(pv_a), .wdata(pv_wd), .rdata(pv_rd));
  ugcl_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_cell (
    .clk(clk), .we(pc_we), .addr(pc_a), .wdata(pc_wd), .rdata(pc_rd));
  ugcl_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_pos (
    .clk(clk), .we(ps_we), .addr(ps_a), .wdata(ps_wd), .rdata(ps_rd));

  // sequencer registers
  ugcl_pkg::state_t state_r, state_nxt;
  ugcl_pkg::in_item_t item_r, item_nxt;
  logic [CW:0]   clr_r, clr_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [14:0]   quo_r, quo_nxt;
  logic [3:0]    bit_r, bit_nxt;
  logic [5:0]    cx_r, cx_nxt, cy_r, cy_nxt;
  logic [CW-1:0] cell_r, cell_nxt;
  logic [PN-1:0] cnt_r, cnt_nxt;
  logic [PN-1:0] wh_r [9];
  logic [PN-1:0] wh_nxt [9];
  logic [3:0]    slot_r, slot_nxt;
  logic [PN-1:0] cur_r, cur_nxt;
  logic [3:0]    qi_r, qi_nxt;
  logic [PN-1:0] t0_r, t0_nxt, t1_r, t1_nxt;
  logic          ov_r, ov_nxt;
  ugcl_pkg::out_item_t oi_r, oi_nxt;

  // shared divide step: restoring, one quotient bit per cycle
  logic [15:0] dvs;
  logic [16:0] trial;
  logic        fits;
  logic [15:0] dend;
  always_comb begin
    dvs   = (state_r == ugcl_pkg::S_DIVX) ? cw_r : ch_r;
    if (dvs == 16'd0) dvs = 16'd1;
    dend  = (state_r == ugcl_pkg::S_DIVX) ? item_r.pos_x : item_r.pos_y;
    trial = {rem_r, dend[bit_r]};
    fits  = trial >= {1'b0, dvs};
  end

  // cell number helper for query slot: returns valid flag and cell
  logic [1:0]  qdx, qdy;
  logic [6:0]  qnx, qny;
  logic        qok;
  logic [11:0] qprod;
  logic [CW-1:0] qcell;
  always_comb begin
    qdx = (qi_r >= 4'd6) ? 2'(qi_r - 4'd6) : ((qi_r >= 4'd3) ? 2'(qi_r - 4'd3) : qi_r[1:0]);
    qdy = (qi_r >= 4'd6) ? 2'd2 : ((qi_r >= 4'd3) ? 2'd1 : 2'd0);
    qnx = {1'b0, cx_r} + {5'd0, qdx};
    qny = {1'b0, cy_r} + {5'd0, qdy};
    qok = (qnx >= 7'd1) && (qny >= 7'd1) && (qnx - 7'd1 < {1'b0, ecols})
          && (qny - 7'd1 < {1'b0, erows});
    qprod = 12'(qny - 7'd1) * 12'(ecols) + 12'(qnx - 7'd1);
    qcell = (qprod >= 12'(MAX_CELLS)) ? CELL_MAX : CW'(qprod);
  end

  logic [11:0]   cprod;
  assign cprod = 12'(cy_r) * 12'(ecols) + 12'(cx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ugcl_pkg::S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
      slot_r  <= 4'd9;
      cur_r   <= NULL_IDX;
      ov_r    <= 1'b0;
      for (int i = 0; i < 9; i++) wh_r[i] <= NULL_IDX;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      slot_r  <= slot_nxt;
      cur_r   <= cur_nxt;
      ov_r    <= ov_nxt;
      for (int i = 0; i < 9; i++) wh_r[i] <= wh_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    bit_r  <= bit_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cell_r <= cell_nxt;
    qi_r   <= qi_nxt;
    t0_r   <= t0_nxt;
    t1_r   <= t1_nxt;
    oi_r   <= oi_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    clr_nxt = clr_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    bit_nxt = bit_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    cell_nxt = cell_r;
    cnt_nxt = cnt_r;
    for (int i = 0; i < 9; i++) wh_nxt[i] = wh_r[i];
    slot_nxt = slot_r;
    cur_nxt = cur_r;
    qi_nxt = qi_r;
    t0_nxt = t0_r;
    t1_nxt = t1_r;
    ov_nxt = 1'b0;
    oi_nxt = oi_r;
    hd_we = 1'b0; hd_a = cell_r; hd_wd = '0;
    nx_we = 1'b0; nx_a = item_r.point_id[PW-1:0]; nx_wd = '0;
    pv_we = 1'b0; pv_a = item_r.point_id[PW-1:0]; pv_wd = '0;
    pc_we = 1'b0; pc_a = item_r.point_id[PW-1:0]; pc_wd = cell_r;
    ps_we = 1'b0; ps_a = item_r.point_id[PW-1:0];
    ps_wd = {item_r.pos_y, item_r.pos_x};

    unique case (state_r)
      ugcl_pkg::S_CLEAR: begin
        hd_we = 1'b1;
        hd_a  = clr_r[CW-1:0];
        hd_wd = NULL_IDX;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (CW+1)'(MAX_CELLS - 1)) state_nxt = ugcl_pkg::S_IDLE;
      end
      ugcl_pkg::S_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          oi_nxt = '0;
          rem_nxt = '0;
          quo_nxt = '0;
          bit_nxt = 4'd15;
          if (in_item.cmd == ugcl_pkg::CMD_NEXT) state_nxt = ugcl_pkg::S_WALK_NX;
          else state_nxt = ugcl_pkg::S_DIVX;
        end
      end
      ugcl_pkg::S_DIVX, ugcl_pkg::S_DIVY: begin
        rem_nxt = fits ? 16'(trial - {1'b0, dvs}) : trial[15:0];
        quo_nxt = {quo_r[13:0], fits};
        bit_nxt = bit_r - 4'd1;
        if (bit_r == 4'd0) begin
          rem_nxt = '0;
          bit_nxt = 4'd15;
          if (state_r == ugcl_pkg::S_DIVX) begin
            cx_nxt = ({quo_r, fits} > 16'(ecols - 6'd1)) ? ecols - 6'd1
                     : 6'({quo_r, fits});
            state_nxt = ugcl_pkg::S_DIVY;
          end else begin
            cy_nxt = ({quo_r, fits} > 16'(erows - 6'd1)) ? erows - 6'd1
                     : 6'({quo_r, fits});
            state_nxt = ugcl_pkg::S_CELL;
          end
        end
      end
      ugcl_pkg::S_CELL: begin
        cell_nxt = (cprod >= 12'(MAX_CELLS)) ? CELL_MAX : CW'(cprod);
        qi_nxt = '0;
        state_nxt = ugcl_pkg::S_DISPATCH;
      end
      ugcl_pkg::S_DISPATCH: begin
        case (ugcl_pkg::cmd_t'(item_r.cmd))
          ugcl_pkg::CMD_ADD: begin
            if (cnt_r >= PN'(MAX_POINTS)) begin
              oi_nxt.status = ugcl_pkg::ST_FULL;
              state_nxt = ugcl_pkg::S_DONE;
            end else begin
              state_nxt = ugcl_pkg::S_ADD_RD;
            end
          end
          ugcl_pkg::CMD_MOVE: begin
            if (PN'(item_r.point_id) >= cnt_r) begin
              oi_nxt.status = ugcl_pkg::ST_UNKNOWN;
              state_nxt = ugcl_pkg::S_DONE;
            end else begin
              state_nxt = ugcl_pkg::S_MV_RD;
            end
          end
          default: state_nxt = ugcl_pkg::S_Q_RD;
        endcase
      end
      ugcl_pkg::S_ADD_RD: begin
        state_nxt = ugcl_pkg::S_ADD_WR;
      end
      ugcl_pkg::S_ADD_WR: begin
        // link new point at head; hd_rd holds old head
        ps_we = 1'b1; ps_a = cnt_r[PW-1:0];
        nx_we = 1'b1; nx_a = cnt_r[PW-1:0]; nx_wd = hd_rd;
        pc_we = 1'b1; pc_a = cnt_r[PW-1:0];
        hd_we = 1'b1; hd_wd = cnt_r;
        pv_we = 1'b1;
        if (hd_rd < NULL_IDX) begin
          pv_a = hd_rd[PW-1:0]; pv_wd = cnt_r;
          t0_nxt = cnt_r;
          state_nxt = ugcl_pkg::S_MV_HWR;
        end else begin
          pv_a = cnt_r[PW-1:0]; pv_wd = NULL_IDX;
          state_nxt = ugcl_pkg::S_DONE;
        end
        oi_nxt.result_index = 10'(cnt_r);
        oi_nxt.cell_id = 10'(cell_r);
        cnt_nxt = cnt_r + 1'b1;
      end
      ugcl_pkg::S_MV_RD: begin
        ps_we = 1'b1;
        oi_nxt.result_index = item_r.point_id;
        oi_nxt.cell_id = 10'(cell_r);
        state_nxt = ugcl_pkg::S_MV_CHK;
      end
      ugcl_pkg::S_MV_CHK: begin
        // pc_rd, nx_rd, pv_rd of the moved point are valid
        t0_nxt = pv_rd;
        t1_nxt = nx_rd;
        if (pc_rd == cell_r) state_nxt = ugcl_pkg::S_DONE;
        else begin
          if (pv_rd < NULL_IDX) begin
            nx_we = 1'b1; nx_a = pv_rd[PW-1:0]; nx_wd = nx_rd;
          end else begin
            hd_we = 1'b1; hd_a = pc_rd; hd_wd = nx_rd;
          end
          state_nxt = ugcl_pkg::S_MV_UNL;
        end
      end
      ugcl_pkg::S_MV_UNL: begin
        if (t1_r < NULL_IDX) begin
          pv_we = 1'b1; pv_a = t1_r[PW-1:0]; pv_wd = t0_r;
        end
        state_nxt = ugcl_pkg::S_MV_UNL2;
      end
      ugcl_pkg::S_MV_UNL2: begin
        state_nxt = ugcl_pkg::S_MV_HRD;
      end
      ugcl_pkg::S_MV_HRD: begin
        // hd_rd is head of target cell (read issued in UNL2 via default addr)
        nx_we = 1'b1; nx_wd = hd_rd;
        pc_we = 1'b1;
        hd_we = 1'b1; hd_wd = PN'(item_r.point_id);
        pv_we = 1'b1;
        if (hd_rd < NULL_IDX) begin
          pv_a = hd_rd[PW-1:0]; pv_wd = PN'(item_r.point_id);
          t0_nxt = PN'(item_r.point_id);
          state_nxt = ugcl_pkg::S_MV_HWR;
        end else begin
          pv_wd = NULL_IDX;
          state_nxt = ugcl_pkg::S_DONE;
        end
      end
      ugcl_pkg::S_MV_HWR: begin
        // finish: prev of the linked point is null
        pv_we = 1'b1; pv_a = t0_r[PW-1:0]; pv_wd = NULL_IDX;
        state_nxt = ugcl_pkg::S_DONE;
      end
      ugcl_pkg::S_Q_RD: begin
        hd_a = qcell;
        state_nxt = ugcl_pkg::S_Q_WR;
      end
      ugcl_pkg::S_Q_WR: begin
        hd_a = qcell;
        wh_nxt[qi_r] = qok ? hd_rd : NULL_IDX;
        if (qi_r == 4'd8) begin
          slot_nxt = 4'd0;
          cur_nxt = NULL_IDX;
          state_nxt = ugcl_pkg::S_WALK_SLOT;
        end else begin
          qi_nxt = qi_r + 4'd1;
          state_nxt = ugcl_pkg::S_Q_RD;
        end
      end
      ugcl_pkg::S_WALK_NX: begin
        nx_a = cur_r[PW-1:0];
        state_nxt = (cur_r < NULL_IDX) ? ugcl_pkg::S_WALK_RD : ugcl_pkg::S_WALK_SLOT;
      end
      ugcl_pkg::S_WALK_RD: begin
        cur_nxt = nx_rd;
        state_nxt = ugcl_pkg::S_WALK_SLOT;
      end
      ugcl_pkg::S_WALK_SLOT: begin
        // skip empty slots, one per cycle
        if (cur_r >= NULL_IDX && slot_r < 4'd9) begin
          cur_nxt = wh_r[slot_r];
          slot_nxt = slot_r + 4'd1;
        end else begin
          if (cur_r > NULL_IDX) cur_nxt = NULL_IDX;
          state_nxt = ugcl_pkg::S_WALK_POS;
        end
      end
      ugcl_pkg::S_WALK_POS: begin
        ps_a = cur_r[PW-1:0];
        state_nxt = ugcl_pkg::S_WALK_OUT;
      end
      ugcl_pkg::S_WALK_OUT: begin
        if (cur_r < NULL_IDX) begin
          oi_nxt.result_index = 10'(cur_r);
          oi_nxt.neighbor_found = 1'b1;
          oi_nxt.neighbor_x = ps_rd[15:0];
          oi_nxt.neighbor_y = ps_rd[31:16];
        end
        state_nxt = ugcl_pkg::S_DONE;
      end
      ugcl_pkg::S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = ugcl_pkg::S_IDLE;
      end
      default: state_nxt = ugcl_pkg::S_IDLE;
    endcase
  end

  assign busy      = (state_r != ugcl_pkg::S_IDLE);
  assign out_valid = ov_r;
  assign out_item  = oi_r;

  a_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= PN'(MAX_POINTS)) else $error("point count overflow");
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= 4'd9) else $error("walk slot out of range");

endmodule
